// ----- sv/half_precision_converter_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the half precision converter
// Concurrent checks with a reset qualifier, same-cycle and next-cycle forms.
// ----------------------------------------------------------------------------
`ifndef HALF_PRECISION_CONVERTER_ASSERT_SVH
`define HALF_PRECISION_CONVERTER_ASSERT_SVH

// same-cycle implication
`define HPC_ASSERT_NOW(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("hpc: same-cycle check failed");

// next-cycle implication
`define HPC_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("hpc: next-cycle check failed");

`endif

// ----- sv/hpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Half precision converter package
// Conversion selector codes, field widths and format constants.
// ----------------------------------------------------------------------------
package hpc_pkg;

	localparam int FUNC_W = 2;
	localparam int DATA_W = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_H2S = 2'd0,
		FUNC_S2H = 2'd1,
		FUNC_B2H = 2'd2
	} func_t;

	localparam logic [7:0]  EXP_BIAS_DIFF   = 8'd112;
	localparam logic [7:0]  EXP_ALL_ONES    = 8'hFF;
	localparam logic [7:0]  S2H_OVF_EXP     = 8'd143;
	localparam logic [7:0]  S2H_MIN_SUB_EXP = 8'd102;
	localparam logic [7:0]  S2H_SUB_SHIFT0  = 8'd126;
	localparam logic [7:0]  H2S_SUB_EXP0    = 8'd103;
	localparam logic [15:0] HALF_INF        = 16'h7C00;
	localparam logic [15:0] HALF_QNAN       = 16'h7E00;
	localparam logic [31:0] SINGLE_INF      = 32'h7F80_0000;
	localparam logic [31:0] SINGLE_NAN_MAN  = 32'h007F_C000;

endpackage

// ----- sv/hpc_stream_if.sv -----
// ----------------------------------------------------------------------------
// Converter stream interfaces
// Valid/ready channels for operands and converted results.
// ----------------------------------------------------------------------------
interface hpc_req_if
	import hpc_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [DATA_W-1:0] operand;

	modport source (output valid, output func, output operand, input ready);
	modport sink   (input valid, input func, input operand, output ready);
endinterface

interface hpc_rsp_if
	import hpc_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] result;

	modport source (output valid, output result, input ready);
	modport sink   (input valid, input result, output ready);
endinterface

// ----- sv/hpc_convert.sv -----
// ----------------------------------------------------------------------------
// Format conversion datapath
// Half to single, single to half and bfloat16 to half, selected by func.
// ----------------------------------------------------------------------------
module hpc_convert
	import hpc_pkg::*;
(
	input  logic [FUNC_W-1:0] func,
	input  logic [DATA_W-1:0] operand,
	output logic [DATA_W-1:0] result
);

	// half to single
	logic        h_sign;
	logic [4:0]  h_exp;
	logic [9:0]  h_man;
	logic [3:0]  h_pos;
	logic [9:0]  h_norm;
	logic [7:0]  h_sub_exp;
	logic [31:0] h_res;

	always_comb begin
		h_sign    = operand[15];
		h_exp     = operand[14:10];
		h_man     = operand[9:0];
		h_pos     = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (h_man[i]) begin
				h_pos = 4'(i);
			end
		end
		h_norm    = h_man << (4'd10 - h_pos);
		h_sub_exp = H2S_SUB_EXP0 + {4'b0, h_pos};
		if (h_exp == 5'd0) begin
			if (h_man == 10'd0) begin
				h_res = {h_sign, 31'd0};
			end else begin
				h_res = {h_sign, h_sub_exp, h_norm, 13'd0};
			end
		end else if (h_exp == 5'h1F) begin
			h_res = {h_sign, 31'd0} | SINGLE_INF | ((h_man != 10'd0) ? SINGLE_NAN_MAN : 32'd0);
		end else begin
			h_res = {h_sign, {3'b0, h_exp} + EXP_BIAS_DIFF, h_man, 13'd0};
		end
	end

	// single to half
	logic        s_sign;
	logic [7:0]  s_be;
	logic [22:0] s_man;
	logic [4:0]  s_shift;
	logic [23:0] s_pre;
	logic [10:0] s_sub;
	logic [4:0]  s_hexp;
	logic [15:0] s_norm;
	logic [15:0] s_res;

	always_comb begin
		s_sign  = operand[31];
		s_be    = operand[30:23];
		s_man   = operand[22:0];
		s_shift = 5'(S2H_SUB_SHIFT0 - s_be);
		s_pre   = {1'b1, s_man} >> (s_shift - 5'd1);
		s_sub   = s_pre[11:1] + {10'd0, s_pre[0]};
		s_hexp  = 5'(s_be - EXP_BIAS_DIFF);
		s_norm  = {1'b0, s_hexp, s_man[22:13]} + {15'd0, s_man[12]};
		if (s_be == 8'd0) begin
			s_res = {s_sign, 15'd0};
		end else if (s_be == EXP_ALL_ONES) begin
			s_res = {s_sign, 15'd0} | ((s_man != 23'd0) ? HALF_QNAN : HALF_INF);
		end else if (s_be >= S2H_OVF_EXP) begin
			s_res = {s_sign, 15'd0} | HALF_INF;
		end else if (s_be <= EXP_BIAS_DIFF) begin
			if (s_be < S2H_MIN_SUB_EXP) begin
				s_res = {s_sign, 15'd0};
			end else begin
				s_res = {s_sign, 4'd0, s_sub};
			end
		end else begin
			s_res = {s_sign, s_norm[14:0]};
		end
	end

	// bfloat16 to half
	logic        b_sign;
	logic [7:0]  b_exp;
	logic [6:0]  b_man;
	logic [15:0] b_res;

	always_comb begin
		b_sign = operand[15];
		b_exp  = operand[14:7];
		b_man  = operand[6:0];
		if (b_exp == EXP_ALL_ONES) begin
			b_res = {b_sign, 15'd0} | ((b_man != 7'd0) ? HALF_QNAN : HALF_INF);
		end else if (b_exp <= EXP_BIAS_DIFF) begin
			b_res = {b_sign, 15'd0};
		end else if (b_exp >= S2H_OVF_EXP) begin
			b_res = {b_sign, 15'd0} | HALF_INF;
		end else begin
			b_res = {b_sign, 5'(b_exp - EXP_BIAS_DIFF), b_man, 3'd0};
		end
	end

	always_comb begin
		case (func)
			FUNC_H2S: result = h_res;
			FUNC_S2H: result = {16'd0, s_res};
			FUNC_B2H: result = {16'd0, b_res};
			default:  result = '0;
		endcase
	end

endmodule

// ----- sv/half_precision_converter.sv -----
// ----------------------------------------------------------------------------
// Half precision converter
// Two-register pipeline around the format conversion datapath.
// ----------------------------------------------------------------------------
//  channel  dir  payload            transaction
//  req      in   func, operand      one operand to convert
//  rsp      out  result             one converted bit pattern
//
//  One transaction per cycle sustained while rsp is ready; each one passes the
//  operand register and then the result register.
//  Reset clears only the valid flags of both registers.
//  A stalled rsp holds the result; req stays ready while the operand register
//  can move into the result register.
// ----------------------------------------------------------------------------
`include "half_precision_converter_assert.svh"

module half_precision_converter
	import hpc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	hpc_req_if.sink   req,
	hpc_rsp_if.source rsp
);

	logic              vld_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [DATA_W-1:0] operand_s1;
	logic              vld_s2;
	logic [DATA_W-1:0] result_s2;
	logic [DATA_W-1:0] conv_result;
	logic              adv_s1;

	assign adv_s1    = vld_s1 && (!vld_s2 || rsp.ready);
	assign req.ready = !vld_s1 || !vld_s2 || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1    <= req.func;
			operand_s1 <= req.operand;
		end
	end

	hpc_convert u_convert (
		.func    (func_s1),
		.operand (operand_s1),
		.result  (conv_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || rsp.ready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= conv_result;
		end
	end

	assign rsp.valid  = vld_s2;
	assign rsp.result = result_s2;

	`HPC_ASSERT_NOW(a_full_stall_blocks, clk, arst_n, vld_s1 && vld_s2 && !rsp.ready, !req.ready)
	`HPC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, req.valid && req.ready, vld_s1)
	`HPC_ASSERT_NOW(a_half_upper_zero, clk, arst_n, vld_s1 && func_s1 != FUNC_H2S, conv_result[31:16] == 16'd0)

endmodule

// ----- dv/half_precision_converter_test.sv -----
// ----------------------------------------------------------------------------
// Half precision converter testbench
// Streams half, single and bfloat16 bit patterns through the converter with
// random idling on both channels, predicts every conversion in the bench and
// compares each returned result in order.
// ----------------------------------------------------------------------------
module half_precision_converter_test
	import hpc_pkg::*;
	;

	localparam logic [1:0]  FUNC_NONE   = 2'd3;
	localparam logic [15:0] HALF_QUIET  = 16'h0200;
	localparam int          STALL_LIMIT = 2000;
	localparam int          HOLD_AFTER  = 500;
	localparam int          HOLD_CYCLES = 400;

	typedef struct {
		logic [1:0]  func;
		logic [31:0] operand;
		int unsigned gap_pct;
	} conv_req_t;

	typedef struct {
		logic [1:0]  func;
		logic [31:0] operand;
		logic [31:0] result;
	} conv_expect_t;

	logic clk;
	logic arst_n;

	hpc_req_if req();
	hpc_rsp_if rsp();

	half_precision_converter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	conv_req_t    pending_ops[$];
	conv_expect_t awaited_results[$];

	int unsigned queued_ops   = 0;
	int unsigned accepted_ops = 0;
	int unsigned mismatches   = 0;
	int unsigned stall_cycles = 0;
	int unsigned send_gap     = 0;
	int unsigned sink_gap     = 0;
	int unsigned sink_pct     = 0;
	int unsigned sink_phase   = 0;
	int unsigned hold_left    = 0;
	logic        hold_done    = 1'b0;
	logic        gap_rolled   = 1'b0;
	logic        calm         = 1'b0;
	logic        req_took     = 1'b0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] convert_bits(input logic [1:0] sel, input logic [31:0] op);
		logic [15:0] hsign;
		logic [10:0] norm;
		logic [31:0] mant;
		int unsigned lz;
		int          ex;
		int          shamt;
		case (sel)
			FUNC_H2S: begin
				if (op[14:10] == 5'd0) begin
					if (op[9:0] == 10'd0)
						return {op[15], 31'd0};
					norm = {1'b0, op[9:0]};
					lz = 0;
					while (!norm[10]) begin
						norm = norm << 1;
						lz++;
					end
					return {op[15], 31'd0} | (32'(113 - lz) << 23) | {9'd0, norm[9:0], 13'd0};
				end
				if (op[14:10] == 5'h1F)
					return {op[15], 31'd0} | SINGLE_INF |
						(op[9:0] != 10'd0 ? SINGLE_NAN_MAN : 32'd0);
				return {op[15], 8'(op[14:10] + 8'd112), op[9:0], 13'd0};
			end
			FUNC_S2H: begin
				hsign = {op[31], 15'd0};
				mant = {9'd0, op[22:0]};
				ex = int'(op[30:23]) - 112;
				if (op[30:23] == 8'd0)
					return {16'd0, hsign};
				if (op[30:23] == EXP_ALL_ONES)
					return {16'd0, hsign | HALF_INF | (mant != 32'd0 ? HALF_QUIET : 16'd0)};
				if (ex >= 31)
					return {16'd0, hsign | HALF_INF};
				if (ex <= 0) begin
					if (ex < -10)
						return {16'd0, hsign};
					mant = mant | 32'h0080_0000;
					shamt = 14 - ex;
					mant = (mant + (32'd1 << (shamt - 1))) >> shamt;
					return {16'd0, hsign | mant[15:0]};
				end
				mant = mant + 32'h0000_1000;
				if (mant[23]) begin
					mant = 32'd0;
					ex++;
					if (ex >= 31)
						return {16'd0, hsign | HALF_INF};
				end
				return {16'd0, hsign | 16'(ex << 10) | 16'(mant >> 13)};
			end
			FUNC_B2H: begin
				hsign = {op[15], 15'd0};
				ex = int'(op[14:7]) - 112;
				if (op[14:7] == EXP_ALL_ONES)
					return {16'd0, hsign | (op[6:0] != 7'd0 ? HALF_QNAN : HALF_INF)};
				if (ex <= 0)
					return {16'd0, hsign};
				if (ex >= 31)
					return {16'd0, hsign | HALF_INF};
				return {16'd0, hsign | 16'(ex << 10) | {6'd0, op[6:0], 3'd0}};
			end
			default: return 32'd0;
		endcase
	endfunction

	function automatic logic [31:0] make_operand(input logic [1:0] sel);
		logic [31:0] op;
		op = $urandom;
		case (sel)
			FUNC_H2S: begin
				case ($urandom_range(0, 5))
					0: op[14:10] = 5'd0;
					1: op[14:10] = 5'h1F;
					default: ;
				endcase
				case ($urandom_range(0, 5))
					0: op[9:0] = 10'd0;
					1: op[9:0] = 10'(1 << $urandom_range(0, 9));
					default: ;
				endcase
			end
			FUNC_S2H: begin
				case ($urandom_range(0, 9))
					0: op[30:23] = 8'd0;
					1: op[30:23] = EXP_ALL_ONES;
					2, 3: op[30:23] = 8'($urandom_range(100, 113));
					4: op[30:23] = 8'($urandom_range(140, 144));
					5, 6, 7: op[30:23] = 8'($urandom_range(113, 142));
					default: ;
				endcase
				case ($urandom_range(0, 5))
					0: op[12:0] = 13'h1000;
					1: op[22:12] = 11'h7FF;
					2: op[22:0] = 23'd0;
					default: ;
				endcase
			end
			FUNC_B2H: begin
				case ($urandom_range(0, 7))
					0: op[14:7] = 8'd0;
					1: op[14:7] = EXP_ALL_ONES;
					2, 3: op[14:7] = 8'($urandom_range(108, 116));
					4: op[14:7] = 8'($urandom_range(139, 146));
					default: ;
				endcase
				if ($urandom_range(0, 5) == 0)
					op[6:0] = 7'd0;
			end
			default: ;
		endcase
		return op;
	endfunction

	function automatic logic [1:0] pick_func();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 6)
			return FUNC_H2S;
		if (r < 13)
			return FUNC_S2H;
		if (r < 19)
			return FUNC_B2H;
		return FUNC_NONE;
	endfunction

	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 25;
			default: return 60;
		endcase
	endfunction

	task automatic queue_op(input logic [1:0] sel, input logic [31:0] op, input int unsigned pct);
		conv_req_t item;
		item.func = sel;
		item.operand = op;
		item.gap_pct = pct;
		pending_ops.push_back(item);
		queued_ops++;
	endtask

	task automatic note_mismatch(input string what, input logic [1:0] sel, input logic [31:0] op,
		input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		$display("MISMATCH %s: func=%0d operand=%08h result=%08h expected=%08h",
			what, sel, op, got, want);
	endtask

	// driver: hold the offered transaction until accepted, then advance
	always @(negedge clk) begin
		conv_req_t nxt;
		logic      offer;
		if (arst_n) begin
			if (!req.valid || req_took) begin
				offer = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_ops.size() > 0) begin
					if (!gap_rolled && $urandom_range(0, 99) < pending_ops[0].gap_pct) begin
						send_gap = $urandom_range(1, 17) - 1;
						gap_rolled = 1'b1;
					end else begin
						nxt = pending_ops.pop_front();
						offer = 1'b1;
						gap_rolled = 1'b0;
					end
				end
				if (offer) begin
					req.valid <= 1'b1;
					req.func <= nxt.func;
					req.operand <= nxt.operand;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall bursts, one long hold to fill the pipeline
	always @(negedge clk) begin
		logic rdy;
		if (arst_n) begin
			rdy = 1'b1;
			if (!hold_done && accepted_ops >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (sink_phase == 0) begin
				sink_phase = 128;
				sink_pct = pick_idle_pct();
			end else begin
				sink_phase--;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (calm) begin
				rdy = 1'b1;
			end else if (sink_gap > 0) begin
				sink_gap--;
				rdy = 1'b0;
			end else if ($urandom_range(0, 99) < sink_pct) begin
				sink_gap = $urandom_range(1, 17) - 1;
				rdy = 1'b0;
			end
			rsp.ready <= rdy;
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		conv_expect_t want;
		conv_expect_t seen;
		logic         rsp_took;
		if (arst_n) begin
			req_took = req.valid && req.ready;
			rsp_took = rsp.valid && rsp.ready;
			if (rsp_took) begin
				if (awaited_results.size() == 0) begin
					note_mismatch("unexpected transaction", 2'd0, 32'd0, rsp.result, 32'd0);
				end else begin
					want = awaited_results.pop_front();
					if (rsp.result !== want.result)
						note_mismatch("result", want.func, want.operand, rsp.result, want.result);
				end
			end
			if (req_took) begin
				seen.func = req.func;
				seen.operand = req.operand;
				seen.result = convert_bits(req.func, req.operand);
				awaited_results.push_back(seen);
				accepted_ops++;
			end
			if (req_took || rsp_took || (pending_ops.size() == 0 && awaited_results.size() == 0))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("half_precision_converter test failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned pct;
		logic [1:0]  sel;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = FUNC_H2S;
		req.operand = 32'd0;
		rsp.ready = 1'b0;

		queue_op(FUNC_H2S, 32'hFFFF_0000, 10);
		queue_op(FUNC_H2S, 32'h0000_8000, 10);
		queue_op(FUNC_H2S, 32'h0000_0001, 10);
		queue_op(FUNC_H2S, 32'h0000_83FF, 10);
		queue_op(FUNC_H2S, 32'h0000_7BFF, 10);
		queue_op(FUNC_H2S, 32'h0000_FC00, 10);
		queue_op(FUNC_H2S, 32'hFFFF_7E01, 10);
		queue_op(FUNC_S2H, 32'h8000_0000, 10);
		queue_op(FUNC_S2H, 32'h0000_0001, 10);
		queue_op(FUNC_S2H, 32'h7F80_0000, 10);
		queue_op(FUNC_S2H, 32'hFF80_0001, 10);
		queue_op(FUNC_S2H, 32'h477F_F000, 10);
		queue_op(FUNC_S2H, 32'h4780_0000, 10);
		queue_op(FUNC_S2H, 32'hB300_0000, 10);
		queue_op(FUNC_S2H, 32'h32FF_FFFF, 10);
		queue_op(FUNC_S2H, 32'h387F_F000, 10);
		queue_op(FUNC_S2H, 32'h3F80_1000, 10);
		queue_op(FUNC_S2H, 32'hBF80_0FFF, 10);
		queue_op(FUNC_B2H, 32'hFFFF_7F80, 10);
		queue_op(FUNC_B2H, 32'h0000_FF81, 10);
		queue_op(FUNC_B2H, 32'h0000_3880, 10);
		queue_op(FUNC_B2H, 32'h0000_3800, 10);
		queue_op(FUNC_B2H, 32'h0000_477F, 10);
		queue_op(FUNC_B2H, 32'h0000_C780, 10);
		queue_op(FUNC_NONE, 32'hFFFF_FFFF, 10);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// pause the sender until every result is back
		while (accepted_ops != queued_ops || awaited_results.size() != 0)
			@(posedge clk);

		pct = 0;
		for (int i = 0; i < 1600; i++) begin
			if (i % 64 == 0)
				pct = pick_idle_pct();
			sel = pick_func();
			queue_op(sel, make_operand(sel), pct);
		end
		while (pending_ops.size() != 0)
			@(posedge clk);

		calm = 1'b1;
		for (int i = 0; i < 300; i++) begin
			sel = pick_func();
			queue_op(sel, make_operand(sel), 0);
		end

		while (accepted_ops != queued_ops || awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("half_precision_converter test passed");
		else
			$display("half_precision_converter test failed");
		$finish;
	end

endmodule

// ----- half_precision_converter.f -----
+incdir+sv
sv/hpc_pkg.sv
sv/hpc_stream_if.sv
sv/hpc_convert.sv
sv/half_precision_converter.sv
dv/half_precision_converter_test.sv
